>>> rtl/assert_macros.svh
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the clock, off during reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// overlapping implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/etpg_pkg.sv
package etpg_pkg;

  localparam int CfgWidth     = 16;
  localparam int EdgeWidth    = 16;
  localparam int LoadWidth    = 16;
  localparam int DivWidth     = 5;
  localparam int ReqWidth     = 2;
  localparam int CfgIdxWidth  = 3;
  localparam int SensorCount  = 3;
  localparam int InDataWidth  = 32;
  localparam int OutDataWidth = 72;

  localparam logic [CfgWidth-1:0] DetPeriodRst = 16'd500;
  localparam logic [CfgWidth-1:0] DetDutyRst   = 16'd150;
  localparam logic [CfgWidth-1:0] GenPeriodRst = 16'd500;

  typedef enum logic [ReqWidth-1:0] {
    REQ_TICK     = 2'd0,
    REQ_LOAD_DET = 2'd1,
    REQ_LOAD_GEN = 2'd2
  } req_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DET_PERIOD     = 3'd0,
    CFG_DET_DUTY       = 3'd1,
    CFG_PULSE_PERIOD   = 3'd2,
    CFG_GEN_HIGH_START = 3'd3,
    CFG_GEN_HIGH_END   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgWidth-1:0] det_period;
    logic [CfgWidth-1:0] det_duty;
    logic [CfgWidth-1:0] pulse_period;
    logic [CfgWidth-1:0] gen_high_start;
    logic [CfgWidth-1:0] gen_high_end;
  } cfg_t;

  // sensor_pins: 0 pa origin, 1 rotator origin, 2 rotator limit
  typedef struct packed {
    logic [ReqWidth-1:0]    req_type;
    logic [LoadWidth-1:0]   load_value;
    logic                   det_enable;
    logic                   gen_enable;
    logic                   ceph_enable;
    logic                   exposing;
    logic                   ring_on;
    logic                   exp_ok_pin;
    logic [SensorCount-1:0] sensor_pins;
  } item_t;

  typedef struct packed {
    logic                   det_sync_level;
    logic                   gen_pulse_level;
    logic                   ceph_trig_level;
    logic [EdgeWidth-1:0]   det_edges;
    logic [EdgeWidth-1:0]   ceph_edges;
    logic [EdgeWidth-1:0]   exp_ok_events;
    logic                   table_strobe;
    logic [SensorCount-1:0] sensor_found;
    logic [EdgeWidth-1:0]   det_count_now;
  } res_t;

endpackage

>>> rtl/etpg_sensor_qual.sv
module etpg_sensor_qual (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic commit_i,
  input  logic pin_i,
  output logic found_d_o
);

  logic [1:0] on_runs_q, on_runs_d;
  logic [1:0] off_runs_q, off_runs_d;
  logic       found_q, found_d;

  always_comb begin
    on_runs_d  = on_runs_q;
    off_runs_d = off_runs_q;
    found_d    = found_q;
    if (step_i) begin
      if (!pin_i) begin
        if (on_runs_q != 2'd3) begin
          on_runs_d = on_runs_q + 2'd1;
        end
        off_runs_d = 2'd0;
        if (!found_q && on_runs_d > 2'd1) begin
          found_d = 1'b1;
        end
      end else begin
        on_runs_d = 2'd0;
        if (off_runs_q != 2'd3) begin
          off_runs_d = off_runs_q + 2'd1;
        end
        if (found_q && off_runs_d > 2'd1) begin
          found_d = 1'b0;
        end
      end
    end
  end

  assign found_d_o = found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_runs_q  <= 2'd0;
      off_runs_q <= 2'd0;
      found_q    <= 1'b0;
    end else if (commit_i) begin
      on_runs_q  <= on_runs_d;
      off_runs_q <= off_runs_d;
      found_q    <= found_d;
    end
  end

endmodule

>>> rtl/etpg_trig_core.sv
module etpg_trig_core #(
  parameter int COUNT_WIDTH   = 16,
  parameter int STROBE_DIVIDE = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           commit_i,
  input  etpg_pkg::item_t item_i,
  input  etpg_pkg::cfg_t  cfg_i,
  output etpg_pkg::res_t  res_o
);
  import etpg_pkg::*;

  localparam int ExtWidth = ((COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth) + 1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [DivWidth-1:0] DivLast = DivWidth'(STROBE_DIVIDE - 1);

  function automatic logic [ExtWidth-1:0] ext_cnt(input logic [COUNT_WIDTH-1:0] c);
    return ExtWidth'(c);
  endfunction

  function automatic logic [ExtWidth-1:0] ext_cfg(input logic [CfgWidth-1:0] v);
    return ExtWidth'(v);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  logic [COUNT_WIDTH-1:0] det_cnt_q, det_cnt_d;
  logic [COUNT_WIDTH-1:0] gen_cnt_q, gen_cnt_d;
  logic                   det_pin_q, det_pin_d;
  logic                   gen_pin_q, gen_pin_d;
  logic                   ceph_pin_q, ceph_pin_d;
  logic                   det_prev_q, det_prev_d;
  logic                   ceph_prev_q, ceph_prev_d;
  logic [EdgeWidth-1:0]   det_tot_q, det_tot_d;
  logic [EdgeWidth-1:0]   ceph_tot_q, ceph_tot_d;
  logic [EdgeWidth-1:0]   ok_tot_q, ok_tot_d;
  logic                   ok_armed_q, ok_armed_d;
  logic [DivWidth-1:0]    div_q, div_d;
  logic                   strobe;
  logic                   sens_step;
  logic [COUNT_WIDTH-1:0] load_sat;
  logic [SensorCount-1:0] found_d;
  req_e                   req;

  assign req = req_e'(item_i.req_type);

  always_comb begin
    if (ExtWidth'(item_i.load_value) > ext_cnt(CountMax)) begin
      load_sat = CountMax;
    end else begin
      load_sat = COUNT_WIDTH'(item_i.load_value);
    end
  end

  always_comb begin
    det_cnt_d   = det_cnt_q;
    gen_cnt_d   = gen_cnt_q;
    det_pin_d   = det_pin_q;
    gen_pin_d   = gen_pin_q;
    ceph_pin_d  = ceph_pin_q;
    det_prev_d  = det_prev_q;
    ceph_prev_d = ceph_prev_q;
    det_tot_d   = det_tot_q;
    ceph_tot_d  = ceph_tot_q;
    ok_tot_d    = ok_tot_q;
    ok_armed_d  = ok_armed_q;
    div_d       = div_q;
    strobe      = 1'b0;
    sens_step   = 1'b0;
    unique case (req)
      REQ_LOAD_DET: det_cnt_d = load_sat;
      REQ_LOAD_GEN: gen_cnt_d = load_sat;
      REQ_TICK: begin
        if (item_i.det_enable) begin
          if (ext_cnt(det_cnt_d) >= ext_cfg(cfg_i.det_period)) begin
            det_cnt_d = '0;
          end
          det_pin_d = (ext_cnt(det_cnt_d) + ext_cfg(cfg_i.det_duty))
                      < ext_cfg(cfg_i.det_period);
          det_cnt_d = bump(det_cnt_d);
        end
        if (item_i.gen_enable) begin
          if (ext_cnt(gen_cnt_d) >= ext_cfg(cfg_i.pulse_period)) begin
            gen_cnt_d = '0;
          end
          gen_pin_d = (ext_cfg(cfg_i.gen_high_start) <= ext_cnt(gen_cnt_d)) &&
                      (ext_cnt(gen_cnt_d) < ext_cfg(cfg_i.gen_high_end));
          gen_cnt_d = bump(gen_cnt_d);
        end
        if (item_i.ceph_enable) begin
          if (ext_cnt(det_cnt_d) >= ext_cfg(cfg_i.det_period)) begin
            det_cnt_d = '0;
          end
          ceph_pin_d = !(ext_cnt(det_cnt_d) < ext_cfg(cfg_i.det_duty));
          det_cnt_d  = bump(det_cnt_d);
        end
        if (item_i.exposing) begin
          div_d = div_q + 1'b1;
          if (div_d > DivLast) begin
            div_d  = '0;
            strobe = 1'b1;
          end
          if (item_i.ring_on) begin
            if (!det_prev_q && det_pin_d) begin
              det_tot_d = det_tot_q + 1'b1;
            end
            det_prev_d = det_pin_d;
            if (!ceph_prev_q && ceph_pin_d) begin
              ceph_tot_d = ceph_tot_q + 1'b1;
            end
            ceph_prev_d = ceph_pin_d;
            if (!item_i.exp_ok_pin && ok_armed_q) begin
              ok_armed_d = 1'b0;
              ok_tot_d   = ok_tot_q + 1'b1;
            end else begin
              ok_armed_d = item_i.exp_ok_pin;
            end
          end
        end else begin
          sens_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  for (genvar k = 0; k < SensorCount; k++) begin : g_sens
    etpg_sensor_qual u_qual (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (sens_step),
      .commit_i  (commit_i),
      .pin_i     (item_i.sensor_pins[k]),
      .found_d_o (found_d[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_cnt_q   <= '0;
      gen_cnt_q   <= '0;
      det_pin_q   <= 1'b1;
      gen_pin_q   <= 1'b0;
      ceph_pin_q  <= 1'b1;
      det_prev_q  <= 1'b1;
      ceph_prev_q <= 1'b1;
      det_tot_q   <= '0;
      ceph_tot_q  <= '0;
      ok_tot_q    <= '0;
      ok_armed_q  <= 1'b1;
      div_q       <= '0;
    end else if (commit_i) begin
      det_cnt_q   <= det_cnt_d;
      gen_cnt_q   <= gen_cnt_d;
      det_pin_q   <= det_pin_d;
      gen_pin_q   <= gen_pin_d;
      ceph_pin_q  <= ceph_pin_d;
      det_prev_q  <= det_prev_d;
      ceph_prev_q <= ceph_prev_d;
      det_tot_q   <= det_tot_d;
      ceph_tot_q  <= ceph_tot_d;
      ok_tot_q    <= ok_tot_d;
      ok_armed_q  <= ok_armed_d;
      div_q       <= div_d;
    end
  end

  always_comb begin
    res_o.det_sync_level  = det_pin_d;
    res_o.gen_pulse_level = gen_pin_d;
    res_o.ceph_trig_level = ceph_pin_d;
    res_o.det_edges       = det_tot_d;
    res_o.ceph_edges      = ceph_tot_d;
    res_o.exp_ok_events   = ok_tot_d;
    res_o.table_strobe    = strobe;
    res_o.sensor_found    = found_d;
    res_o.det_count_now   = EdgeWidth'(det_cnt_d);
  end

endmodule

>>> rtl/exposure_trigger_pulse_generator_unit.sv
// A result beat passes through the input register and then the result register;
// it is held back only while the result side holds off.
// Throughput: one beat per cycle; the input register and the result register
// both move on every cycle that the result register is empty or its beat is taken.
// Reset (rst_ni low, asynchronous): pipeline empty, configuration back to its
// defaults, counters, totals and sensor state cleared, pins at idle levels.
module exposure_trigger_pulse_generator_unit #(
  parameter int COUNT_WIDTH   = 16,
  parameter int STROBE_DIVIDE = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] load_value, [16] det_enable, [17] gen_enable, [18] ceph_enable,
  // [19] exposing, [20] ring_on, [21] exp_ok_pin, [22] pa_org_pin,
  // [23] ro_org_pin, [24] ro_limit_pin, [31:25] zero
  input  logic [etpg_pkg::InDataWidth-1:0]     s_axis_tdata,
  // [1:0] req_type
  input  logic [etpg_pkg::ReqWidth-1:0]        s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] det_sync_level, [1] gen_pulse_level, [2] ceph_trig_level,
  // [18:3] det_edges, [34:19] ceph_edges, [50:35] exp_ok_events,
  // [51] table_strobe, [52] pa_org_found, [53] ro_org_found,
  // [54] ro_limit_found, [70:55] det_count_now, [71] zero
  output logic [etpg_pkg::OutDataWidth-1:0]    m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [etpg_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [etpg_pkg::CfgWidth-1:0]        cfg_data_i
);
  import etpg_pkg::*;

  cfg_t  cfg_q;
  item_t in_item_q;
  logic  in_vld_q;
  res_t  out_res_q;
  logic  out_vld_q;
  res_t  res;
  logic  adv;
  logic  in_acc;

  assign cfg_ready_o   = 1'b1;
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.det_period     <= DetPeriodRst;
      cfg_q.det_duty       <= DetDutyRst;
      cfg_q.pulse_period   <= GenPeriodRst;
      cfg_q.gen_high_start <= '0;
      cfg_q.gen_high_end   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DET_PERIOD:     cfg_q.det_period     <= cfg_data_i;
        CFG_DET_DUTY:       cfg_q.det_duty       <= cfg_data_i;
        CFG_PULSE_PERIOD:   cfg_q.pulse_period   <= cfg_data_i;
        CFG_GEN_HIGH_START: cfg_q.gen_high_start <= cfg_data_i;
        CFG_GEN_HIGH_END:   cfg_q.gen_high_end   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_item_q.req_type    <= s_axis_tuser;
      in_item_q.load_value  <= s_axis_tdata[15:0];
      in_item_q.det_enable  <= s_axis_tdata[16];
      in_item_q.gen_enable  <= s_axis_tdata[17];
      in_item_q.ceph_enable <= s_axis_tdata[18];
      in_item_q.exposing    <= s_axis_tdata[19];
      in_item_q.ring_on     <= s_axis_tdata[20];
      in_item_q.exp_ok_pin  <= s_axis_tdata[21];
      in_item_q.sensor_pins <= s_axis_tdata[24:22];
    end
    if (adv) begin
      out_res_q <= res;
    end
  end

  etpg_trig_core #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .STROBE_DIVIDE (STROBE_DIVIDE)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (adv),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.det_count_now,
                          out_res_q.sensor_found,
                          out_res_q.table_strobe,
                          out_res_q.exp_ok_events,
                          out_res_q.ceph_edges,
                          out_res_q.det_edges,
                          out_res_q.ceph_trig_level,
                          out_res_q.gen_pulse_level,
                          out_res_q.det_sync_level};

endmodule

>>> rtl/etpg_checker.sv
`include "assert_macros.svh"

module etpg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [etpg_pkg::OutDataWidth-1:0] m_axis_tdata,
  input logic                              cfg_ready_o
);

  // a stalled result beat holds
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata)), "result beat changed while stalled")

  // an accepted beat shows up on the result side after the input and result registers
  `ASSERT_IMPL(a_in_to_out, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid, "accepted beat produced no result")

  // input stalls only when the result side is stalled
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without result backpressure")

  // config channel never blocks
  `ASSERT_PROP(a_cfg_ready, clk_i, rst_ni, cfg_ready_o, "config channel not ready")

endmodule

bind exposure_trigger_pulse_generator_unit etpg_checker u_etpg_checker (.*);

>>> sim/exposure_trigger_pulse_generator_unit_test.sv
`timescale 1ns / 1ps

module exposure_trigger_pulse_generator_unit_test;
  import etpg_pkg::*;

  localparam logic [ReqWidth-1:0] ReqUnused = 2'd3;
  localparam int StrobeDivide  = 20;
  localparam int HoldOffCycles = 400;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 4;
  localparam int PrintLimit    = 40;

  typedef enum logic [1:0] {
    RUN_EXPOSURE,
    RUN_PARKED,
    RUN_LOAD,
    RUN_NOISE
  } run_kind_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic [ReqWidth-1:0]     s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [CfgWidth-1:0]     cfg_data_i = '0;

  exposure_trigger_pulse_generator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of configuration and state
  logic [15:0] cfg_det_period   = DetPeriodRst;
  logic [15:0] cfg_det_duty     = DetDutyRst;
  logic [15:0] cfg_pulse_period = GenPeriodRst;
  logic [15:0] cfg_gen_start    = '0;
  logic [15:0] cfg_gen_end      = '0;

  logic [15:0] shared_cnt = '0;
  logic [15:0] gen_cnt    = '0;
  logic        sync_lvl   = 1'b1;
  logic        xray_lvl   = 1'b0;
  logic        ceph_lvl   = 1'b1;
  logic        sync_last  = 1'b1;
  logic        ceph_last  = 1'b1;
  logic [15:0] sync_rises = '0;
  logic [15:0] ceph_rises = '0;
  logic [15:0] ok_events  = '0;
  logic        ok_ready   = 1'b1;
  logic [4:0]  strobe_phase = '0;
  logic [1:0]  low_run  [SensorCount] = '{default: '0};
  logic [1:0]  high_run [SensorCount] = '{default: '0};
  logic [SensorCount-1:0] sensed = '0;

  res_t        trig_expected [$];
  item_t       taken_beat;
  res_t        want_res;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned burst_left     = 0;

  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;
  logic [7:0]  ready_pattern = 8'hFF;
  int unsigned ready_phase   = 0;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic res_t advance_triggers(item_t beat);
    res_t r;
    logic strobe;
    strobe = 1'b0;
    case (beat.req_type)
      REQ_LOAD_DET: shared_cnt = beat.load_value;
      REQ_LOAD_GEN: gen_cnt = beat.load_value;
      REQ_TICK: begin
        if (beat.det_enable) begin
          if (shared_cnt >= cfg_det_period) shared_cnt = '0;
          sync_lvl = ({1'b0, shared_cnt} + {1'b0, cfg_det_duty}) < {1'b0, cfg_det_period};
          shared_cnt = sat_inc(shared_cnt);
        end
        if (beat.gen_enable) begin
          if (gen_cnt >= cfg_pulse_period) gen_cnt = '0;
          xray_lvl = (cfg_gen_start <= gen_cnt) && (gen_cnt < cfg_gen_end);
          gen_cnt = sat_inc(gen_cnt);
        end
        if (beat.ceph_enable) begin
          if (shared_cnt >= cfg_det_period) shared_cnt = '0;
          ceph_lvl = !(shared_cnt < cfg_det_duty);
          shared_cnt = sat_inc(shared_cnt);
        end
        if (beat.exposing) begin
          strobe_phase = strobe_phase + 5'd1;
          if (strobe_phase > StrobeDivide - 1) begin
            strobe_phase = '0;
            strobe = 1'b1;
          end
          if (beat.ring_on) begin
            if (!sync_last && sync_lvl) sync_rises = sync_rises + 16'd1;
            sync_last = sync_lvl;
            if (!ceph_last && ceph_lvl) ceph_rises = ceph_rises + 16'd1;
            ceph_last = ceph_lvl;
            if (!beat.exp_ok_pin && ok_ready) begin
              ok_ready = 1'b0;
              ok_events = ok_events + 16'd1;
            end else begin
              ok_ready = beat.exp_ok_pin;
            end
          end
        end else begin
          for (int k = 0; k < SensorCount; k++) begin
            if (!beat.sensor_pins[k]) begin
              if (low_run[k] != 2'd3) low_run[k] = low_run[k] + 2'd1;
              high_run[k] = '0;
              if (!sensed[k] && low_run[k] > 2'd1) sensed[k] = 1'b1;
            end else begin
              low_run[k] = '0;
              if (high_run[k] != 2'd3) high_run[k] = high_run[k] + 2'd1;
              if (sensed[k] && high_run[k] > 2'd1) sensed[k] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    r.det_sync_level  = sync_lvl;
    r.gen_pulse_level = xray_lvl;
    r.ceph_trig_level = ceph_lvl;
    r.det_edges       = sync_rises;
    r.ceph_edges      = ceph_rises;
    r.exp_ok_events   = ok_events;
    r.table_strobe    = strobe;
    r.sensor_found    = sensed;
    r.det_count_now   = shared_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PrintLimit) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h at result %0d",
                                name, got, want, results_seen));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DET_PERIOD:     cfg_det_period   = cfg_data_i;
        CFG_DET_DUTY:       cfg_det_duty     = cfg_data_i;
        CFG_PULSE_PERIOD:   cfg_pulse_period = cfg_data_i;
        CFG_GEN_HIGH_START: cfg_gen_start    = cfg_data_i;
        CFG_GEN_HIGH_END:   cfg_gen_end      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      taken_beat.req_type    = s_axis_tuser;
      taken_beat.load_value  = s_axis_tdata[15:0];
      taken_beat.det_enable  = s_axis_tdata[16];
      taken_beat.gen_enable  = s_axis_tdata[17];
      taken_beat.ceph_enable = s_axis_tdata[18];
      taken_beat.exposing    = s_axis_tdata[19];
      taken_beat.ring_on     = s_axis_tdata[20];
      taken_beat.exp_ok_pin  = s_axis_tdata[21];
      taken_beat.sensor_pins = s_axis_tdata[24:22];
      trig_expected.push_back(advance_triggers(taken_beat));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (trig_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", results_seen));
      end else begin
        want_res = trig_expected.pop_front();
        check_field("det_sync_level", 16'(m_axis_tdata[0]), 16'(want_res.det_sync_level));
        check_field("gen_pulse_level", 16'(m_axis_tdata[1]), 16'(want_res.gen_pulse_level));
        check_field("ceph_trig_level", 16'(m_axis_tdata[2]), 16'(want_res.ceph_trig_level));
        check_field("det_edges", m_axis_tdata[18:3], want_res.det_edges);
        check_field("ceph_edges", m_axis_tdata[34:19], want_res.ceph_edges);
        check_field("exp_ok_events", m_axis_tdata[50:35], want_res.exp_ok_events);
        check_field("table_strobe", 16'(m_axis_tdata[51]), 16'(want_res.table_strobe));
        check_field("pa_org_found", 16'(m_axis_tdata[52]), 16'(want_res.sensor_found[0]));
        check_field("ro_org_found", 16'(m_axis_tdata[53]), 16'(want_res.sensor_found[1]));
        check_field("ro_limit_found", 16'(m_axis_tdata[54]), 16'(want_res.sensor_found[2]));
        check_field("det_count_now", m_axis_tdata[70:55], want_res.det_count_now);
      end
    end
  end

  // result side: stall pattern, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldOffCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (ready_phase[5:0] == 6'd0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = 8'hFF;
          1: ready_pattern = 8'($urandom);
          2: ready_pattern = 8'h11;
          default: ready_pattern = 8'($urandom) | 8'hAA;
        endcase
      end
      m_axis_tready <= ready_pattern[ready_phase[2:0]];
      ready_phase++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_cfg_beat();
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_config(logic [15:0] sync_period, logic [15:0] sync_duty,
                            logic [15:0] xray_period, logic [15:0] xray_start,
                            logic [15:0] xray_end);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_DET_PERIOD;
    cfg_data_i  <= sync_period;
    wait_cfg_beat();
    cfg_index_i <= CFG_DET_DUTY;
    cfg_data_i  <= sync_duty;
    wait_cfg_beat();
    cfg_index_i <= CFG_PULSE_PERIOD;
    cfg_data_i  <= xray_period;
    wait_cfg_beat();
    cfg_index_i <= CFG_GEN_HIGH_START;
    cfg_data_i  <= xray_start;
    wait_cfg_beat();
    cfg_index_i <= CFG_GEN_HIGH_END;
    cfg_data_i  <= xray_end;
    wait_cfg_beat();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_beat(item_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= beat.req_type;
    s_axis_tdata  <= {7'd0, beat.sensor_pins, beat.exp_ok_pin, beat.ring_on, beat.exposing,
                      beat.ceph_enable, beat.gen_enable, beat.det_enable, beat.load_value};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (trig_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // enables: [0] det, [1] gen, [2] ceph
  function automatic item_t tick_beat(logic [2:0] enables, logic exposing, logic ring,
                                      logic ok_pin, logic [2:0] sensors);
    item_t b;
    b.req_type    = REQ_TICK;
    b.load_value  = 16'($urandom);
    b.det_enable  = enables[0];
    b.gen_enable  = enables[1];
    b.ceph_enable = enables[2];
    b.exposing    = exposing;
    b.ring_on     = ring;
    b.exp_ok_pin  = ok_pin;
    b.sensor_pins = sensors;
    return b;
  endfunction

  task automatic test_load_and_unused();
    item_t b;
    b = tick_beat(3'b111, 1'b1, 1'b1, 1'b0, 3'b000);
    b.req_type   = REQ_LOAD_DET;
    b.load_value = 16'hFFFF;
    send_beat(b);
    b.req_type   = REQ_LOAD_GEN;
    b.load_value = 16'h0000;
    send_beat(b);
    b.req_type   = ReqUnused;
    b.load_value = 16'hFFFF;
    send_beat(b);
    // counter above period is cleared before use
    send_beat(tick_beat(3'b001, 1'b0, 1'b0, 1'b1, 3'b111));
    wait_results_done();
  endtask

  task automatic test_duty_and_period_cases();
    // duty above period, generator period zero, empty window
    set_config(16'd3, 16'd5, 16'd0, 16'hFFFF, 16'd0);
    repeat (4) send_beat(tick_beat(3'b111, 1'b0, 1'b0, 1'b1, 3'b111));
    wait_results_done();
  endtask

  task automatic test_gen_window();
    set_config(16'hFFFF, 16'd0, 16'd4, 16'd1, 16'd3);
    repeat (5) send_beat(tick_beat(3'b110, 1'b0, 1'b0, 1'b1, 3'b111));
    wait_results_done();
  endtask

  task automatic test_exposure_counting();
    set_config(16'd2, 16'd1, 16'd500, 16'd0, 16'd0);
    send_beat(tick_beat(3'b001, 1'b1, 1'b1, 1'b1, 3'b000));
    send_beat(tick_beat(3'b001, 1'b1, 1'b1, 1'b0, 3'b000));
    send_beat(tick_beat(3'b101, 1'b1, 1'b1, 1'b0, 3'b000));
    send_beat(tick_beat(3'b100, 1'b1, 1'b1, 1'b1, 3'b000));
    send_beat(tick_beat(3'b101, 1'b1, 1'b1, 1'b0, 3'b000));
    send_beat(tick_beat(3'b001, 1'b1, 1'b0, 1'b1, 3'b000));
    wait_results_done();
  endtask

  task automatic test_sensor_qualification();
    send_beat(tick_beat(3'b000, 1'b0, 1'b0, 1'b1, 3'b000));
    send_beat(tick_beat(3'b000, 1'b0, 1'b0, 1'b1, 3'b000));
    send_beat(tick_beat(3'b000, 1'b0, 1'b0, 1'b1, 3'b101));
    send_beat(tick_beat(3'b000, 1'b0, 1'b0, 1'b1, 3'b111));
    send_beat(tick_beat(3'b000, 1'b0, 1'b0, 1'b1, 3'b111));
    send_beat(tick_beat(3'b000, 1'b0, 1'b0, 1'b1, 3'b010));
    wait_results_done();
  endtask

  task automatic test_output_hold_off();
    set_config(16'd7, 16'd3, 16'd5, 16'd1, 16'd4);
    hold_req = 1'b1;
    repeat (40) send_beat(tick_beat(3'($urandom), 1'b1, 1'b1, 1'($urandom), 3'($urandom)));
    wait_results_done();
  endtask

  task automatic test_random_traffic(int unsigned total);
    item_t       b;
    int unsigned sent;
    int unsigned run_len;
    int unsigned pick;
    int unsigned sp;
    int unsigned gp;
    logic [2:0]  enables;
    logic [2:0]  sensors;
    logic        ok_level;
    run_kind_e   kind;
    sent = 0;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        1: set_config(16'd1, 16'd0, 16'd1, 16'd0, 16'd1);
        2: set_config(16'hFFFF, 16'd0, 16'd2, 16'hFFFF, 16'hFFFF);
        default: begin
          sp = $urandom_range(1, 24);
          gp = $urandom_range(0, 24);
          set_config(16'(sp), 16'($urandom_range(0, sp + 3)), 16'(gp),
                     16'($urandom_range(0, gp)), 16'($urandom_range(0, gp + 2)));
        end
      endcase
      while (sent < total * (phase + 1) / 7) begin
        pick = $urandom_range(0, 9);
        kind = (pick < 5) ? RUN_EXPOSURE : (pick < 8) ? RUN_PARKED :
               (pick == 8) ? RUN_LOAD : RUN_NOISE;
        case (kind)
          RUN_EXPOSURE: begin
            run_len  = $urandom_range(8, 60);
            enables  = 3'($urandom | $urandom);
            ok_level = 1'($urandom);
            repeat (run_len) begin
              if ($urandom_range(0, 3) == 0) ok_level = !ok_level;
              if ($urandom_range(0, 15) == 0) enables = 3'($urandom);
              send_beat(tick_beat(enables, 1'b1, $urandom_range(0, 7) != 0, ok_level,
                                  3'($urandom)));
              sent++;
            end
          end
          RUN_PARKED: begin
            run_len = $urandom_range(4, 30);
            sensors = 3'($urandom);
            repeat (run_len) begin
              sensors = sensors ^ 3'($urandom & $urandom);
              send_beat(tick_beat(3'($urandom), 1'b0, 1'($urandom), 1'($urandom), sensors));
              sent++;
            end
          end
          RUN_LOAD: begin
            b = tick_beat(3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                          3'($urandom));
            b.req_type   = $urandom_range(0, 1) ? REQ_LOAD_DET : REQ_LOAD_GEN;
            b.load_value = $urandom_range(0, 1) ? 16'($urandom_range(0, 30)) : 16'($urandom);
            send_beat(b);
            sent++;
          end
          default: begin
            b = tick_beat(3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                          3'($urandom));
            b.req_type = 2'($urandom);
            send_beat(b);
            sent++;
          end
        endcase
      end
      wait_results_done();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_and_unused();
    test_duty_and_period_cases();
    test_gen_window();
    test_exposure_counting();
    test_sensor_qualification();
    test_output_hold_off();
    test_random_traffic(700);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
